// ===== rtl/core/dwhm_pkg.sv =====
package dwhm_pkg;

    // Fixed field widths
    localparam int BASE_W     = 2;
    localparam int CHAR_W     = 8;
    localparam int QUERY_W    = 16;
    localparam int QUERY_BASES = QUERY_W / BASE_W;
    localparam int MIS_W      = 5;
    localparam int POS_W      = 16;
    localparam int TOTAL_W    = 32;
    localparam int CFG_DATA_W = 16;

    localparam int HALF_BASES_DEF = 8;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam logic [MIS_W-1:0] MIS_MAX = {MIS_W{1'b1}};

    // Base codes
    localparam logic [BASE_W-1:0] CODE_A = 2'd0;
    localparam logic [BASE_W-1:0] CODE_C = 2'd1;
    localparam logic [BASE_W-1:0] CODE_G = 2'd2;
    localparam logic [BASE_W-1:0] CODE_T = 2'd3;

    typedef enum logic [1:0] {
        CFG_PREFIX  = 2'd0,
        CFG_VARIANT = 2'd1,
        CFG_SUFFIX  = 2'd2,
        CFG_LIMIT   = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [CHAR_W-1:0] base_char;
        logic              last_of_read;
    } base_req_t;

    typedef struct packed {
        logic               window_ok;
        logic [MIS_W-1:0]   mismatches;
        logic               hit;
        logic [POS_W-1:0]   hit_position;
        logic               miss_at_end;
        logic [TOTAL_W-1:0] valid_windows;
    } result_t;

    typedef struct packed {
        logic              ok;
        logic [BASE_W-1:0] code;
    } base_code_t;

    // ASCII base letter A, C, G or T (either case) to two-bit code; anything else is flagged invalid
    function automatic base_code_t base_code(input logic [CHAR_W-1:0] ch);
        base_code_t bc;
        bc.ok   = 1'b1;
        bc.code = CODE_A;
        case (ch)
            8'h41, 8'h61: bc.code = CODE_A;
            8'h43, 8'h63: bc.code = CODE_C;
            8'h47, 8'h67: bc.code = CODE_G;
            8'h54, 8'h74: bc.code = CODE_T;
            default:      bc.ok   = 1'b0;
        endcase
        return bc;
    endfunction

endpackage

// ===== rtl/core/dna_window_hamming_matcher.sv =====
// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+------------------------------
// base      | in        | base_valid / base_stall   | base_req (base_char, last_of_read)
// result    | out       | result_valid / result_stall | result (window_ok .. valid_windows)
// cfg       | in        | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One request per cycle sustained while base_stall stays low; result_valid rises once
// the request has passed the cell row and the skid's output register.
// The cell row shifts on acceptance; scoring reads the row once the skid has room.
// Reset clears the cell row, counters, flags and query registers at once; no sweep.
// A stalled result parks in a one-entry skid, so base_stall rises only when both
// the skid and the row's pending request are occupied.
module dna_window_hamming_matcher #(
    parameter int HALF_BASES = dwhm_pkg::HALF_BASES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // base channel
    input  logic                            base_valid,
    output logic                            base_stall,
    input  dwhm_pkg::base_req_t             base_req,
    // result channel
    output logic                            result_valid,
    input  logic                            result_stall,
    output dwhm_pkg::result_t               result,
    // configuration
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  dwhm_pkg::cfg_index_t            cfg_index,
    input  logic [dwhm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dwhm_pkg::*;

    localparam int WIN_BASES = 2 * HALF_BASES + 1;
    localparam int RUN_W     = $clog2(WIN_BASES + 1);
    localparam int CNT_W     = $clog2(2 * HALF_BASES + 1);
    localparam int SUM_W     = (CNT_W > MIS_W) ? CNT_W : MIS_W;

    // ------------------------------------------------------------------
    // Query registers
    // ------------------------------------------------------------------
    logic [QUERY_W-1:0] prefix_reg;
    logic [BASE_W-1:0]  variant_reg;
    logic [QUERY_W-1:0] suffix_reg;
    logic [MIS_W-1:0]   limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg  <= '0;
            variant_reg <= '0;
            suffix_reg  <= '0;
            limit_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PREFIX:  prefix_reg  <= cfg_data;
                CFG_VARIANT: variant_reg <= cfg_data[BASE_W-1:0];
                CFG_SUFFIX:  suffix_reg  <= cfg_data;
                CFG_LIMIT:   limit_reg   <= cfg_data[MIS_W-1:0];
                default:     ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage one: accept a base, shift the cell row, track run and position
    // ------------------------------------------------------------------
    logic              accept;
    logic              eval;
    logic              skid_full;
    logic              s1_valid_reg;
    logic              last_reg;      // request in the row closed its read
    logic [RUN_W-1:0]  run_reg;
    logic [RUN_W-1:0]  run_base;
    logic [RUN_W-1:0]  run_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_base;
    logic [POS_W-1:0]  pos_next;
    base_code_t        bc;

    assign base_stall = s1_valid_reg && skid_full;
    assign accept     = base_valid && !base_stall;
    assign eval       = s1_valid_reg && !skid_full;

    assign bc = base_code(base_req.base_char);

    // after the last base of a read, per-read state starts from empty
    assign run_base = last_reg ? '0 : run_reg;
    assign pos_base = last_reg ? '0 : pos_reg;

    always_comb
    begin
        if (!bc.ok)
        begin
            run_next = '0;
        end
        else if (run_base < RUN_W'(WIN_BASES))
        begin
            run_next = run_base + RUN_W'(1);
        end
        else
        begin
            run_next = run_base;
        end
        pos_next = (pos_base == POS_MAX) ? pos_base : pos_base + POS_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            last_reg     <= 1'b0;
            run_reg      <= '0;
            pos_reg      <= '0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
            last_reg     <= base_req.last_of_read;
            run_reg      <= run_next;
            pos_reg      <= pos_next;
        end
        else if (eval)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Cell row: cell 0 newest, cell HALF_BASES is the middle base
    // ------------------------------------------------------------------
    logic [BASE_W-1:0] cell_base [WIN_BASES];
    logic [BASE_W-1:0] cell_query [WIN_BASES];
    logic [WIN_BASES-1:0] cell_mis;

    for (genvar i = 0; i < WIN_BASES; i++)
    begin : g_cell
        if (i < HALF_BASES)
        begin : g_suffix
            if (i < QUERY_BASES)
            begin : g_in
                assign cell_query[i] = suffix_reg[BASE_W*i +: BASE_W];
            end
            else
            begin : g_out
                assign cell_query[i] = '0;
            end
        end
        else if (i == HALF_BASES)
        begin : g_mid
            assign cell_query[i] = variant_reg;
        end
        else
        begin : g_prefix
            if (i - HALF_BASES - 1 < QUERY_BASES)
            begin : g_in
                assign cell_query[i] = prefix_reg[BASE_W*(i-HALF_BASES-1) +: BASE_W];
            end
            else
            begin : g_out
                assign cell_query[i] = '0;
            end
        end

        if (i == 0)
        begin : g_head
            dwhm_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .shift      (accept),
                .flush      (1'b0),
                .base_in    (bc.code),
                .query_base (cell_query[i]),
                .base_out   (cell_base[i]),
                .mismatch   (cell_mis[i])
            );
        end
        else
        begin : g_body
            dwhm_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .shift      (accept),
                .flush      (last_reg),
                .base_in    (cell_base[i-1]),
                .query_base (cell_query[i]),
                .base_out   (cell_base[i]),
                .mismatch   (cell_mis[i])
            );
        end
    end

    // ------------------------------------------------------------------
    // Stage two: score the held window and decide hit / miss
    // ------------------------------------------------------------------
    logic               wok;
    logic [CNT_W-1:0]   mis_cnt;
    logic [SUM_W-1:0]   distance;
    logic               found_reg;
    logic               found_next;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;
    result_t            res;

    assign wok = (run_reg == RUN_W'(WIN_BASES)) && !cell_mis[HALF_BASES];

    // popcount over flanking cells, middle cell excluded
    always_comb
    begin
        mis_cnt = '0;
        for (int i = 0; i < WIN_BASES; i++)
        begin
            if (i != HALF_BASES)
            begin
                mis_cnt = mis_cnt + CNT_W'(cell_mis[i]);
            end
        end
    end

    assign distance = wok ? SUM_W'(mis_cnt) : '0;

    always_comb
    begin
        res            = '0;
        found_next     = found_reg;
        total_next     = total_reg;
        res.window_ok  = wok;
        res.mismatches = (distance > SUM_W'(MIS_MAX)) ? MIS_MAX : MIS_W'(distance);
        if (wok && !found_reg)
        begin
            total_next = total_reg + TOTAL_W'(1);
            if (distance <= SUM_W'(limit_reg))
            begin
                res.hit          = 1'b1;
                res.hit_position = pos_reg;
                found_next       = 1'b1;
            end
        end
        res.miss_at_end   = last_reg && !found_next;
        res.valid_windows = total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            total_reg <= '0;
        end
        else if (eval)
        begin
            found_reg <= found_next && !last_reg;
            total_reg <= total_next;
        end
    end

    dwhm_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (eval),
        .push_data (res),
        .full      (skid_full),
        .out_valid (result_valid),
        .out_stall (result_stall),
        .out_data  (result)
    );

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_hit_needs_window: assert property (@(posedge clk) disable iff (!rst_n)
        eval && res.hit |-> res.window_ok && (distance <= SUM_W'(limit_reg)))
        else $error("hit raised without a qualifying window");

    a_hit_miss_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.hit && result.miss_at_end))
        else $error("hit and miss reported together");

    a_found_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
        eval && res.hit && !last_reg |=> found_reg)
        else $error("found flag not set after hit");

    a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        eval |=> (total_reg == $past(total_reg))
              || (total_reg == $past(total_reg) + TOTAL_W'(1)))
        else $error("window total moved by more than one");

endmodule

// ===== rtl/core/dwhm_cell.sv =====
module dwhm_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       shift,
    input  logic                       flush,
    input  logic [dwhm_pkg::BASE_W-1:0] base_in,
    input  logic [dwhm_pkg::BASE_W-1:0] query_base,
    output logic [dwhm_pkg::BASE_W-1:0] base_out,
    output logic                       mismatch
);
    import dwhm_pkg::*;

    logic [BASE_W-1:0] base_reg;
    logic [BASE_W-1:0] base_next;

    // flush: neighbour belonged to the finished read, take an empty base
    assign base_next = flush ? '0 : base_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (shift)
        begin
            base_reg <= base_next;
        end
    end

    assign base_out = base_reg;
    assign mismatch = (base_reg != query_base);

endmodule

// ===== rtl/core/dwhm_skid.sv =====
module dwhm_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dwhm_pkg::result_t push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output dwhm_pkg::result_t out_data
);
    import dwhm_pkg::*;

    logic    out_valid_reg;
    result_t out_data_reg;
    logic    skid_valid_reg;
    result_t skid_data_reg;
    logic    out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (push)
            begin
                out_data_reg <= push_data;
            end
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
